// ===== rtl/ptt_pkg.sv =====
// Shared types and constants for the periodic timer table.
// No dependencies; imported by ptt_rem, the core, the checker and the bench.
package ptt_pkg;

    localparam int T_W       = 48;
    localparam int SLOT_W    = 4;
    localparam int MODE_W    = 2;
    localparam int SLOTS_DEF = 16;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISARM = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [T_W-1:0]    now;
        logic [T_W-1:0]    first_deadline;
        logic [T_W-1:0]    period;
    } t_in;

    typedef struct packed {
        logic              fired;
        logic [SLOT_W-1:0] fired_slot;
        logic [T_W-1:0]    new_deadline;
        logic              last;
    } t_out;

    // Status of the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

// ===== rtl/ptt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ptt_rem.sv =====
// Iterative remainder unit: one restoring step per cycle.
// Depends on ptt_pkg.
module ptt_rem
    import ptt_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [T_W-1:0] i_dividend,
    input  logic [T_W-1:0] i_divisor,
    output t_rem_stat      o_stat,
    output logic [T_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(T_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [T_W-1:0]   r_sh;
    logic [T_W-1:0]   r_div;
    logic [T_W-1:0]   r_rem;
    logic [T_W:0]     n_trial;
    logic             n_ge;

    // Shift in the next dividend bit and compare with the divisor
    assign n_trial = {r_rem, r_sh[T_W-1]};
    assign n_ge    = (n_trial >= {1'b0, r_div});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(T_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: subtract when the partial remainder reaches the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh <= {r_sh[T_W-2:0], 1'b0};
            if (n_ge) begin
                r_rem <= T_W'(n_trial - {1'b0, r_div});
            end else begin
                r_rem <= n_trial[T_W-1:0];
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_rem  = r_rem;

endmodule

// ===== rtl/periodic_timer_table_core.sv =====
// Periodic timer table. Arm, disarm and unused-mode beats stay in S_IDLE.
// A tick walks the slots: each slot passes S_READ and S_CHECK, a fired
// one-shot slot adds S_PUSH, a fired periodic slot adds S_DIV (catch-up
// remainder unit, one bit per cycle) and S_PUSH; S_FLUSH sends the final
// result. Synchronous active-low reset clears the slot valid bits; an
// unwritten slot reads as disarmed with period zero. No clearing pass.
module periodic_timer_table_core
    import ptt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_in,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_out
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DIV,
        S_PUSH,
        S_FLUSH
    } t_state;

    t_state           r_state;
    logic [IW-1:0]    r_idx;
    logic [T_W-1:0]   r_now;
    logic [T_W-1:0]   r_per;
    logic [T_W-1:0]   r_nd;
    logic [SLOTS-1:0] r_valid;
    logic             r_rd_vld;
    logic             r_pend_valid;
    logic [IW-1:0]    r_pend_slot;
    logic [T_W-1:0]   r_pend_nd;
    logic             r_o_valid;
    t_out             r_o_out;

    logic             in_acc;
    logic             in_range;
    logic             out_free;
    logic             at_end;
    logic             we_dl;
    logic             we_per;
    logic [IW-1:0]    waddr;
    logic [T_W-1:0]   wdata_dl;
    logic             re;
    logic [T_W-1:0]   dl_q;
    logic [T_W-1:0]   per_q;
    logic [T_W-1:0]   d;
    logic [T_W-1:0]   p;
    logic             fire;
    logic             rem_start;
    t_rem_stat        rem_stat;
    logic [T_W-1:0]   rem;
    logic [T_W:0]     sum;
    logic [T_W-1:0]   sat_nd;
    logic             push_go;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign in_range = ({{(9 - SLOT_W){1'b0}}, i_in.slot} < 9'(SLOTS));
    assign out_free = !r_o_valid || i_ready;
    assign at_end   = (r_idx == IW'(SLOTS - 1));

    // Slot contents, an unwritten slot reads as zero
    assign d    = r_rd_vld ? dl_q : '0;
    assign p    = r_rd_vld ? per_q : '0;
    assign fire = (d != '0) && (d <= r_now);
    assign rem_start = (r_state == S_CHECK) && fire && (p != '0);

    // Catch-up deadline: now - ((now - d) mod p) + p, saturated
    assign sum    = {1'b0, T_W'(r_now - rem)} + {1'b0, r_per};
    assign sat_nd = sum[T_W] ? '1 : sum[T_W-1:0];

    assign push_go = !r_pend_valid || out_free;

    // Store write and read controls
    always_comb begin
        we_dl    = 1'b0;
        we_per   = 1'b0;
        waddr    = r_idx;
        wdata_dl = r_nd;
        re       = (r_state == S_READ);
        if (r_state == S_IDLE) begin
            waddr = IW'(i_in.slot);
            if (in_acc && in_range) begin
                unique case (i_in.mode)
                    MODE_ARM: begin
                        we_dl    = 1'b1;
                        we_per   = 1'b1;
                        wdata_dl = i_in.first_deadline;
                    end
                    MODE_DISARM: begin
                        we_dl    = 1'b1;
                        wdata_dl = '0;
                    end
                    default: begin
                        we_dl = 1'b0;
                    end
                endcase
            end
        end else if (r_state == S_PUSH && push_go) begin
            we_dl = 1'b1;
        end
    end

    ptt_ram #(.WIDTH(T_W), .DEPTH(SLOTS)) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (we_dl),
        .i_waddr (waddr),
        .i_wdata (wdata_dl),
        .i_re    (re),
        .i_raddr (r_idx),
        .o_rdata (dl_q)
    );

    ptt_ram #(.WIDTH(T_W), .DEPTH(SLOTS)) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (we_per),
        .i_waddr (waddr),
        .i_wdata (i_in.period),
        .i_re    (re),
        .i_raddr (r_idx),
        .o_rdata (per_q)
    );

    ptt_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (T_W'(r_now - d)),
        .i_divisor  (p),
        .o_stat     (rem_stat),
        .o_rem      (rem)
    );

    // Sequencer, valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.mode == MODE_ARM && in_range) begin
                            r_valid[IW'(i_in.slot)] <= 1'b1;
                        end
                        if (i_in.mode == MODE_TICK) begin
                            r_now        <= i_in.now;
                            r_idx        <= '0;
                            r_pend_valid <= 1'b0;
                            r_state      <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_rd_vld <= r_valid[r_idx];
                    r_state  <= S_CHECK;
                end
                S_CHECK: begin
                    r_per <= p;
                    if (fire && p != '0) begin
                        r_state <= S_DIV;
                    end else if (fire) begin
                        r_nd    <= '0;
                        r_state <= S_PUSH;
                    end else if (at_end) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DIV: begin
                    if (rem_stat.done) begin
                        r_nd    <= sat_nd;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    // Release the held result, keep the new one until the
                    // walk shows whether it is the last
                    if (push_go) begin
                        if (r_pend_valid) begin
                            r_o_valid              <= 1'b1;
                            r_o_out.fired          <= 1'b1;
                            r_o_out.fired_slot     <= SLOT_W'(r_pend_slot);
                            r_o_out.new_deadline   <= r_pend_nd;
                            r_o_out.last           <= 1'b0;
                        end
                        r_pend_valid <= 1'b1;
                        r_pend_slot  <= r_idx;
                        r_pend_nd    <= r_nd;
                        if (at_end) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_o_valid    <= 1'b1;
                        r_o_out.last <= 1'b1;
                        if (r_pend_valid) begin
                            r_o_out.fired        <= 1'b1;
                            r_o_out.fired_slot   <= SLOT_W'(r_pend_slot);
                            r_o_out.new_deadline <= r_pend_nd;
                        end else begin
                            r_o_out.fired        <= 1'b0;
                            r_o_out.fired_slot   <= '0;
                            r_o_out.new_deadline <= '0;
                        end
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_o_valid;
    assign o_out   = r_o_out;

endmodule

// ===== rtl/ptt_checker.sv =====
// Port-level checks for the periodic timer table, bound to the top level.
// Depends on ptt_pkg and periodic_timer_table_core.
module ptt_checker
    import ptt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input t_in  i_in,
    input logic o_valid,
    input logic i_ready,
    input t_out o_out
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // A not-fired result closes its tick
    a_nofire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.fired |-> o_out.last && o_out.fired_slot == '0
            && o_out.new_deadline == '0)
        else $error("not-fired result malformed");

    // A tick occupies the block
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_in.mode == MODE_TICK |=> !o_ready)
        else $error("ready after tick beat");

    // Drop results at reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind periodic_timer_table_core ptt_checker u_ptt_checker (.*);

// ===== bench/periodic_timer_table_core_tb.sv =====
// Self-checking bench for periodic_timer_table_core: directed table, then random beats.
// Depends on ptt_pkg and the core RTL; the expected results come from a
// timer-table model in this file.
module periodic_timer_table_core_tb;
    import ptt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = SLOTS_DEF;
    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RAND_ITEMS = 300;
    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int DRAIN_CYCLES = 1000;
    localparam t_out NOT_FIRED = '{fired: 1'b0, fired_slot: '0, new_deadline: '0,
                                   last: 1'b1};

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_stim_row;

    // DUT ports; the inputs are known from time zero
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_out;

    // Model state of the timer table
    logic [T_W-1:0] due_at [SLOTS] = '{default: '0};
    logic [T_W-1:0] rep_per [SLOTS] = '{default: '0};

    t_out      due_fires [$];
    t_out      step_res [$];
    t_stim_row stim_rows [$];

    // Side info that travels with the beat on i_in
    bit   row_typed = 1'b0;
    t_out row_want = '0;

    bit tx_idle_ok = 1'b1;
    bit rx_idle_ok = 1'b1;
    int stall_left = 0;
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int fires_seen = 0;
    int cycles = 0;

    periodic_timer_table_core #(.SLOTS(SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    always #1 i_clk = ~i_clk;

    // Advance a due time by whole periods past now; clamp at the top of the time range
    function automatic logic [T_W-1:0] next_due(logic [T_W-1:0] d, logic [T_W-1:0] per,
                                                 logic [T_W-1:0] nw);
        logic [63:0] steps;
        logic [63:0] nd;
        steps = (64'(nw) - 64'(d)) / 64'(per) + 64'd1;
        nd = 64'(d) + steps * 64'(per);
        if (nd > 64'(T_MAX)) begin
            nd = 64'(T_MAX);
        end
        return nd[T_W-1:0];
    endfunction

    // Apply one beat to the table model and collect the results it causes
    function automatic void timer_step(input t_in it, ref t_out res[$]);
        logic [T_W-1:0] nd;
        t_out r;
        res.delete();
        case (it.mode)
            MODE_ARM: begin
                due_at[it.slot] = it.first_deadline;
                rep_per[it.slot] = it.period;
            end
            MODE_DISARM: begin
                due_at[it.slot] = '0;
            end
            MODE_TICK: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (due_at[s] != '0 && due_at[s] <= it.now) begin
                        nd = (rep_per[s] != '0) ? next_due(due_at[s], rep_per[s], it.now) : '0;
                        due_at[s] = nd;
                        r = '{fired: 1'b1, fired_slot: SLOT_W'(s), new_deadline: nd, last: 1'b0};
                        res.push_back(r);
                    end
                end
                if (res.size() == 0) begin
                    res.push_back(NOT_FIRED);
                end else begin
                    res[res.size()-1].last = 1'b1;
                end
            end
            default: ;  // unused mode: drop the beat
        endcase
    endfunction

    function automatic logic [T_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[T_W-1:0];
    endfunction

    function automatic void add_row(logic [MODE_W-1:0] m, logic [SLOT_W-1:0] sl,
                                    logic [T_W-1:0] nw, logic [T_W-1:0] fd,
                                    logic [T_W-1:0] per, bit typed = 1'b0,
                                    t_out want = '0);
        t_stim_row row;
        row.item = '{mode: m, slot: sl, now: nw, first_deadline: fd, period: per};
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    // Drive one beat, with an optional gap ahead of it, and hold it until accepted
    task automatic send_beat(t_in it, bit typed, t_out want);
        if (tx_idle_ok && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= it;
        row_typed <= typed;
        row_want <= want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Predict on accepted input beats, check accepted result beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                beats_in++;
                timer_step(i_in, step_res);
                if (row_typed) begin
                    if (step_res.size() != 1 || step_res[0] !== row_want) begin
                        report("model against table row", step_res.size(), 1);
                    end
                    due_fires.push_back(row_want);
                end else begin
                    foreach (step_res[k]) due_fires.push_back(step_res[k]);
                end
            end
            if (o_valid && i_ready) begin
                beats_out++;
                if (due_fires.size() == 0) begin
                    report("result beat with nothing pending, slot", o_out.fired_slot, 0);
                end else begin
                    t_out want;
                    want = due_fires.pop_front();
                    if (o_out.fired !== want.fired) report("fired", o_out.fired, want.fired);
                    if (o_out.fired_slot !== want.fired_slot)
                        report("fired_slot", o_out.fired_slot, want.fired_slot);
                    if (o_out.new_deadline !== want.new_deadline)
                        report("new_deadline", o_out.new_deadline, want.new_deadline);
                    if (o_out.last !== want.last) report("last", o_out.last, want.last);
                    if (want.fired) fires_seen++;
                end
            end
        end
    end

    // Receiver stalls in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (rx_idle_ok && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 6) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog on the whole run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending", cycles,
                     due_fires.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_in            it;
        logic [T_W-1:0] sim_now;
        int             r;

        // Directed table: reset state, extremes, one-shot, catch-up and clamping
        add_row(MODE_TICK, 4'd0, 48'd0, 48'd0, 48'd0, 1'b1, NOT_FIRED);
        add_row(MODE_TICK, 4'd0, T_MAX, 48'd0, 48'd0, 1'b1, NOT_FIRED);
        add_row(MODE_ARM, 4'd0, 48'd0, 48'd1, 48'd0);
        add_row(MODE_ARM, 4'd15, 48'd0, T_MAX, T_MAX);
        add_row(MODE_ARM, 4'd5, 48'd0, 48'd100, 48'd7);
        add_row(MODE_ARM, 4'd7, 48'd0, 48'd0, 48'd3);
        add_row(MODE_UNUSED, 4'hA, T_MAX, 48'h1234_5678_9ABC, 48'hFEDC_BA98_7654);
        add_row(MODE_TICK, 4'd0, 48'd0, 48'd0, 48'd0, 1'b1, NOT_FIRED);
        add_row(MODE_TICK, 4'd0, 48'd1, 48'd0, 48'd0, 1'b1,
                '{fired: 1'b1, fired_slot: 4'd0, new_deadline: '0, last: 1'b1});
        add_row(MODE_TICK, 4'd0, 48'd250, 48'd0, 48'd0);
        add_row(MODE_ARM, 4'd3, 48'd0, T_MAX - 48'd5, 48'd10);
        add_row(MODE_ARM, 4'd2, 48'd0, 48'd5, 48'd1);
        add_row(MODE_TICK, 4'd0, T_MAX - 48'd1, 48'd0, 48'd0);
        add_row(MODE_TICK, 4'd0, T_MAX, 48'd0, 48'd0);
        add_row(MODE_DISARM, 4'd3, 48'd0, 48'd0, 48'd0);
        add_row(MODE_DISARM, 4'd0, 48'd0, 48'd0, 48'd0);
        add_row(MODE_ARM, 4'd9, 48'd0, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
        add_row(MODE_ARM, 4'd6, 48'd0, 48'hAAAA_AAAA_AAAA, 48'd0);
        add_row(MODE_TICK, 4'd0, 48'hAAAA_AAAA_AAAA, 48'd0, 48'd0);
        add_row(MODE_DISARM, 4'd2, 48'd0, 48'd0, 48'd0);
        add_row(MODE_DISARM, 4'd5, 48'd0, 48'd0, 48'd0);
        add_row(MODE_DISARM, 4'd15, 48'd0, 48'd0, 48'd0);
        add_row(MODE_DISARM, 4'd9, 48'd0, 48'd0, 48'd0);
        add_row(MODE_TICK, 4'd0, T_MAX, 48'd0, 48'd0, 1'b1, NOT_FIRED);

        // Hold reset, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k])
            send_beat(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].want);

        // Random part: mostly arms and ticks on a moving time base
        sim_now = 48'd1000;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            tx_idle_ok = !((n >= 100 && n < 160) || n >= RAND_ITEMS - 60);
            rx_idle_ok = tx_idle_ok;
            it = '{mode: MODE_TICK, slot: 4'($urandom_range(0, 15)), now: rand48(),
                   first_deadline: rand48(), period: rand48()};
            r = $urandom_range(0, 99);
            if (r < 5) begin
                it.mode = MODE_UNUSED;
            end else if (r < 45) begin
                it.mode = MODE_ARM;
                case ($urandom_range(0, 9))
                    0: it.first_deadline = '0;
                    1: ;  // keep the full-range deadline
                    default: it.first_deadline = sim_now + 48'($urandom_range(1, 3000));
                endcase
                case ($urandom_range(0, 7))
                    0, 1: it.period = '0;
                    2: ;  // keep the full-range period
                    default: it.period = 48'($urandom_range(1, 800));
                endcase
            end else if (r < 58) begin
                it.mode = MODE_DISARM;
            end else begin
                case ($urandom_range(0, 39))
                    0, 1: sim_now = rand48();
                    2: sim_now = T_MAX - 48'($urandom_range(0, 2000));
                    3: sim_now = 48'($urandom_range(0, 5000));
                    default: sim_now = sim_now + 48'($urandom_range(0, 600));
                endcase
                it.now = sim_now;
            end
            send_beat(it, 1'b0, '0);
        end
        i_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (due_fires.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats and %0d result beats, %0d of them fired slots",
                 beats_in, beats_out, fires_seen);
        $display("mismatches: %0d, cycles: %0d", errors, cycles);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== periodic_timer_table_core.f =====
rtl/ptt_pkg.sv
rtl/ptt_ram.sv
rtl/ptt_rem.sv
rtl/periodic_timer_table_core.sv
rtl/ptt_checker.sv
bench/periodic_timer_table_core_tb.sv
